@@ rtl/dcer_pkg.sv @@
// ----------------------------------------------------------------------------
// dcer_pkg
// shared types, codes and helpers of the dual controller byte router
// ----------------------------------------------------------------------------
package dcer_pkg;

    // panel command and fill codes
    localparam logic [7:0] CMD_COLOR    = 8'h12;
    localparam logic [7:0] CMD_END      = 8'h11;
    localparam logic [7:0] OFFLINE_FILL = 8'h55;

    localparam int unsigned PLANE_W    = 20;
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 20;

    // configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_REVERSE_BITS = 3'd0,
        REG_OFFLINE_MODE = 3'd1,
        REG_PLANE_BYTES  = 3'd2,
        REG_COLOR_ARG0   = 3'd3,
        REG_COLOR_ARG1   = 3'd4,
        REG_COLOR_ARG2   = 3'd5
    } t_cfg_reg;

    // output sequence of one input word
    typedef enum logic [2:0] {
        SEQ_DATA,
        SEQ_CMD_COLOR,
        SEQ_ARG0,
        SEQ_ARG1,
        SEQ_ARG2,
        SEQ_CMD_END
    } t_seq;

    // one routed image word and whether the plane-switch burst follows it
    typedef struct packed {
        logic [7:0] data;
        logic       master;
        logic       slave;
        logic       burst;
    } t_item;

    // colour-plane command arguments
    typedef struct packed {
        logic [7:0] arg0;
        logic [7:0] arg1;
        logic [7:0] arg2;
    } t_color_args;

    // swap nibbles, then bit pairs, then neighbor bits
    function automatic logic [7:0] flip_byte(input logic [7:0] b);
        logic [7:0] v;
        v = ((b & 8'hF0) >> 4) | ((b & 8'h0F) << 4);
        v = ((v & 8'hCC) >> 2) | ((v & 8'h33) << 2);
        v = ((v & 8'hAA) >> 1) | ((v & 8'h55) << 1);
        return v;
    endfunction

endpackage

@@ rtl/dual_controller_epd_byte_router.sv @@
// ----------------------------------------------------------------------------
// dual_controller_epd_byte_router
// routes image bytes of a two-controller e-paper panel to master and slave
// ----------------------------------------------------------------------------
// Usage
//   pixel channel (i_pixel_valid / o_pixel_stall / i_pixel_byte) takes one
//   image word per cycle unless stalled. spi channel (o_spi_valid /
//   i_spi_stall) delivers one serial-link word per cycle unless stalled,
//   with its DC flag, both chip selects and a last flag on the final word
//   caused by each image word. An accepted word passes the skid register
//   and then the output register before it is sent. Throughput is one
//   image word per cycle unless stalled; the word ending the first plane
//   produces six output words (data, cmd 0x12, three colour bytes, cmd
//   0x11), sent one per cycle by the output sequencer; input stalls behind it.
//   A skid register sits in front of the output register, so a new word is
//   taken while a finished word waits; with the receiver stalled both fill
//   and o_pixel_stall rises, payloads held.
//   Reset (i_rst_n low, synchronous) empties both stages, sets the first
//   plane with the master selected and loads register defaults
//   (plane length 1). The user must write registers via i_cfg_we / i_cfg_addr
//   and i_cfg_wdata only while the block is idle, which it does not enforce.
// ----------------------------------------------------------------------------
module dual_controller_epd_byte_router #(
    parameter int unsigned ROW_BYTES      = 120,
    parameter int unsigned HALF_ROW_BYTES = 60
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [dcer_pkg::CFG_ADDR_W-1:0]   i_cfg_addr,
    input  logic [dcer_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    input  logic                              i_pixel_valid,
    output logic                              o_pixel_stall,
    input  logic [7:0]                        i_pixel_byte,
    output logic                              o_spi_valid,
    input  logic                              i_spi_stall,
    output logic [7:0]                        o_spi_byte,
    output logic                              o_is_command,
    output logic                              o_master_select,
    output logic                              o_slave_select,
    output logic                              o_last
);

    logic                          r_reverse_bits;
    logic                          r_offline_mode;
    logic [dcer_pkg::PLANE_W-1:0]  r_plane_bytes;
    dcer_pkg::t_color_args         r_args;

    dcer_pkg::t_item item;
    logic            take;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_reverse_bits <= 1'b0;
            r_offline_mode <= 1'b0;
            r_plane_bytes  <= dcer_pkg::PLANE_W'(1);
            r_args         <= '0;
        end else if (i_cfg_we) begin
            case (dcer_pkg::t_cfg_reg'(i_cfg_addr))
                dcer_pkg::REG_REVERSE_BITS: r_reverse_bits <= i_cfg_wdata[0];
                dcer_pkg::REG_OFFLINE_MODE: r_offline_mode <= i_cfg_wdata[0];
                dcer_pkg::REG_PLANE_BYTES:  r_plane_bytes  <= i_cfg_wdata[dcer_pkg::PLANE_W-1:0];
                dcer_pkg::REG_COLOR_ARG0:   r_args.arg0    <= i_cfg_wdata[7:0];
                dcer_pkg::REG_COLOR_ARG1:   r_args.arg1    <= i_cfg_wdata[7:0];
                dcer_pkg::REG_COLOR_ARG2:   r_args.arg2    <= i_cfg_wdata[7:0];
                default: ;
            endcase
        end
    end

    assign take = i_pixel_valid && !o_pixel_stall;

    // byte path and plane tracking
    dcer_route #(
        .ROW_BYTES      (ROW_BYTES),
        .HALF_ROW_BYTES (HALF_ROW_BYTES)
    ) u_route (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_take         (take),
        .i_pixel_byte   (i_pixel_byte),
        .i_reverse_bits (r_reverse_bits),
        .i_offline_mode (r_offline_mode),
        .i_plane_bytes  (r_plane_bytes),
        .o_item         (item)
    );

    // skid and output sequencer
    dcer_burst u_burst (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_pixel_valid),
        .i_item          (item),
        .o_stall         (o_pixel_stall),
        .i_args          (r_args),
        .o_valid         (o_spi_valid),
        .i_stall         (i_spi_stall),
        .o_spi_byte      (o_spi_byte),
        .o_is_command    (o_is_command),
        .o_master_select (o_master_select),
        .o_slave_select  (o_slave_select),
        .o_last          (o_last)
    );

endmodule

@@ rtl/dcer_route.sv @@
// ----------------------------------------------------------------------------
// dcer_route
// per-word data path and plane/row tracking: byte count, row position,
// plane index and chip select state
// ----------------------------------------------------------------------------
module dcer_route #(
    parameter int unsigned ROW_BYTES      = 120,
    parameter int unsigned HALF_ROW_BYTES = 60
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_take,
    input  logic [7:0]                        i_pixel_byte,
    input  logic                              i_reverse_bits,
    input  logic                              i_offline_mode,
    input  logic [dcer_pkg::PLANE_W-1:0]      i_plane_bytes,
    output dcer_pkg::t_item                   o_item
);

    localparam int unsigned POS_W = (ROW_BYTES > 2) ? $clog2(ROW_BYTES) : 1;

    logic [dcer_pkg::PLANE_W-1:0] r_byte_count, n_byte_count;
    logic [POS_W-1:0]             r_row_pos, n_row_pos;
    logic                         r_plane, n_plane;
    logic                         r_master, n_master;
    logic                         r_slave, n_slave;

    logic [dcer_pkg::PLANE_W-1:0] count_inc;
    logic [POS_W-1:0]             pos_inc;
    logic                         plane_end;
    logic [7:0]                   data_out;

    // data byte of this word
    always_comb begin
        data_out = i_reverse_bits ? dcer_pkg::flip_byte(i_pixel_byte) : i_pixel_byte;
        if (i_offline_mode && !r_plane && (r_row_pos == '0)) begin
            data_out = dcer_pkg::OFFLINE_FILL;
        end
    end

    // count and row position advance
    assign count_inc = r_byte_count + 1'b1;
    assign pos_inc   = (r_row_pos == POS_W'(ROW_BYTES - 1)) ? '0 : r_row_pos + 1'b1;
    assign plane_end = (count_inc >= i_plane_bytes);

    assign o_item.data   = data_out;
    assign o_item.master = r_master;
    assign o_item.slave  = r_slave;
    assign o_item.burst  = plane_end && !r_plane;

    // next tracking state
    always_comb begin
        n_byte_count = count_inc;
        n_row_pos    = pos_inc;
        n_plane      = r_plane;
        n_master     = r_master;
        n_slave      = r_slave;
        if (pos_inc == POS_W'(HALF_ROW_BYTES)) begin
            n_master = 1'b0;
            n_slave  = 1'b1;
        end else if (pos_inc == '0) begin
            n_slave  = 1'b0;
            n_master = 1'b1;
        end
        if (plane_end) begin
            n_byte_count = '0;
            n_row_pos    = '0;
            if (!r_plane) begin
                n_master = 1'b1;
                n_slave  = 1'b0;
                n_plane  = 1'b1;
            end else begin
                n_slave  = 1'b0;
                n_plane  = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= '0;
            r_row_pos    <= '0;
            r_plane      <= 1'b0;
            r_master     <= 1'b1;
            r_slave      <= 1'b0;
        end else if (i_take) begin
            r_byte_count <= n_byte_count;
            r_row_pos    <= n_row_pos;
            r_plane      <= n_plane;
            r_master     <= n_master;
            r_slave      <= n_slave;
        end
    end

endmodule

@@ rtl/dcer_burst.sv @@
// ----------------------------------------------------------------------------
// dcer_burst
// skid register plus output sequencer: sends the data word and, after the
// first plane, the colour-plane command sequence
// ----------------------------------------------------------------------------
module dcer_burst (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  dcer_pkg::t_item        i_item,
    output logic                   o_stall,
    input  dcer_pkg::t_color_args  i_args,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [7:0]             o_spi_byte,
    output logic                   o_is_command,
    output logic                   o_master_select,
    output logic                   o_slave_select,
    output logic                   o_last
);

    logic            r_a_valid;
    dcer_pkg::t_item r_a_item;
    logic            r_b_valid;
    dcer_pkg::t_item r_b_item;
    dcer_pkg::t_seq  r_seq, n_seq;

    logic out_take;
    logic b_free;
    logic a_move;
    logic in_take;

    // handshake between skid and output stage
    assign out_take = r_b_valid && !i_stall;
    assign b_free   = !r_b_valid || (out_take && o_last);
    assign a_move   = r_a_valid && b_free;
    assign o_stall  = r_a_valid && !b_free;
    assign in_take  = i_valid && !o_stall;
    assign o_valid  = r_b_valid;

    // skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (in_take) begin
            r_a_valid <= 1'b1;
        end else if (a_move) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_a_item <= i_item;
        end
    end

    // next sequence step
    always_comb begin
        n_seq = r_seq;
        if (a_move) begin
            n_seq = dcer_pkg::SEQ_DATA;
        end else if (out_take) begin
            case (r_seq)
                dcer_pkg::SEQ_DATA:      n_seq = dcer_pkg::SEQ_CMD_COLOR;
                dcer_pkg::SEQ_CMD_COLOR: n_seq = dcer_pkg::SEQ_ARG0;
                dcer_pkg::SEQ_ARG0:      n_seq = dcer_pkg::SEQ_ARG1;
                dcer_pkg::SEQ_ARG1:      n_seq = dcer_pkg::SEQ_ARG2;
                dcer_pkg::SEQ_ARG2:      n_seq = dcer_pkg::SEQ_CMD_END;
                default:                 n_seq = dcer_pkg::SEQ_DATA;
            endcase
        end
    end

    // output stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_seq     <= dcer_pkg::SEQ_DATA;
        end else begin
            r_seq <= n_seq;
            if (a_move) begin
                r_b_valid <= 1'b1;
            end else if (out_take && o_last) begin
                r_b_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_move) begin
            r_b_item <= r_a_item;
        end
    end

    // fields of the current word
    always_comb begin
        o_spi_byte      = r_b_item.data;
        o_is_command    = 1'b0;
        o_master_select = 1'b1;
        o_slave_select  = 1'b1;
        o_last          = 1'b0;
        case (r_seq)
            dcer_pkg::SEQ_DATA: begin
                o_master_select = r_b_item.master;
                o_slave_select  = r_b_item.slave;
                o_last          = !r_b_item.burst;
            end
            dcer_pkg::SEQ_CMD_COLOR: begin
                o_spi_byte   = dcer_pkg::CMD_COLOR;
                o_is_command = 1'b1;
            end
            dcer_pkg::SEQ_ARG0: o_spi_byte = i_args.arg0;
            dcer_pkg::SEQ_ARG1: o_spi_byte = i_args.arg1;
            dcer_pkg::SEQ_ARG2: o_spi_byte = i_args.arg2;
            dcer_pkg::SEQ_CMD_END: begin
                o_spi_byte   = dcer_pkg::CMD_END;
                o_is_command = 1'b1;
                o_last       = 1'b1;
            end
            default: o_last = 1'b1;
        endcase
    end

endmodule

@@ rtl/dcer_checker.sv @@
// ----------------------------------------------------------------------------
// dcer_checker
// port-level checks of the byte router, bound to the top level
// ----------------------------------------------------------------------------
module dcer_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_spi_valid,
    input logic       i_spi_stall,
    input logic [7:0] o_spi_byte,
    input logic       o_is_command,
    input logic       o_master_select,
    input logic       o_slave_select,
    input logic       o_last
);

    // stalled output word holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_spi_valid && i_spi_stall) |=> (o_spi_valid && $stable(o_spi_byte)
            && $stable(o_is_command) && $stable(o_last)))
        else $error("stalled output word changed");

    // command words go to both controllers
    a_cmd_selects: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_spi_valid && o_is_command) |-> (o_master_select && o_slave_select))
        else $error("command word without both selects");

    // colour command is never the final word of a burst
    a_color_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_spi_valid && o_is_command && (o_spi_byte == dcer_pkg::CMD_COLOR))
            |-> !o_last)
        else $error("colour command flagged last");

    // colour command is followed at once by an argument data word
    a_color_args: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_spi_valid && !i_spi_stall && o_is_command
            && (o_spi_byte == dcer_pkg::CMD_COLOR))
            |=> (o_spi_valid && !o_is_command && !o_last
                && o_master_select && o_slave_select))
        else $error("colour command not followed by argument");

endmodule

bind dual_controller_epd_byte_router dcer_checker u_dcer_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_spi_valid     (o_spi_valid),
    .i_spi_stall     (i_spi_stall),
    .o_spi_byte      (o_spi_byte),
    .o_is_command    (o_is_command),
    .o_master_select (o_master_select),
    .o_slave_select  (o_slave_select),
    .o_last          (o_last)
);
